// ===== hw/rtl/rsmad_pkg.sv =====
// Package for the RGB signature mean-absolute-difference block.
// Holds the widths, register indexes and sequencer states. It depends on nothing.
`timescale 1ns / 1ps

package rsmad_pkg;

  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned LimitW    = 10;
  localparam int unsigned MinW      = 9;
  localparam int unsigned AvgW      = 10;
  localparam int unsigned CntW      = $clog2(MaxBlocks + 1);
  // The total and the threshold sum both stay at or below 1023 * MaxBlocks.
  localparam int unsigned SumW      = $clog2(1023 * MaxBlocks + 1);
  localparam int unsigned DivCntW   = $clog2(SumW);
  localparam int unsigned CmpW      = (CntW > MinW) ? CntW : MinW;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic {
    REG_DIFF_LIMIT = 1'b0,
    REG_MIN_BLOCKS = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_LIMIT,
    S_CHECK,
    S_DECIDE,
    S_DIV,
    S_FIX,
    S_OUT
  } state_e;

endpackage

// ===== hw/rtl/rsmad_if.sv =====
// Handshake channels of the block: block pairs in, comparison results out.
// Depends on rsmad_pkg for the field widths.
`timescale 1ns / 1ps

interface rsmad_pair_if;
  logic                         valid;
  logic                         ready;
  logic [rsmad_pkg::ColorW-1:0] first_red;
  logic [rsmad_pkg::ColorW-1:0] first_green;
  logic [rsmad_pkg::ColorW-1:0] first_blue;
  logic [rsmad_pkg::ColorW-1:0] second_red;
  logic [rsmad_pkg::ColorW-1:0] second_green;
  logic [rsmad_pkg::ColorW-1:0] second_blue;
  logic                         last_block;

  modport source (output valid, first_red, first_green, first_blue, second_red,
                  second_green, second_blue, last_block, input ready);
  modport sink (input valid, first_red, first_green, first_blue, second_red,
                second_green, second_blue, last_block, output ready);
endinterface

interface rsmad_result_if;
  logic                       valid;
  logic                       ready;
  logic [rsmad_pkg::AvgW-1:0] average_diff;
  logic                       stopped_early;

  modport source (output valid, average_diff, stopped_early, input ready);
  modport sink (input valid, average_diff, stopped_early, output ready);
endinterface

// ===== hw/rtl/rgb_signature_mean_abs_diff.sv =====
// Top level: streaming mean absolute difference of two RGB signatures, early stop.
// Depends on rsmad_pkg and the channels in rsmad_if.sv.
//
//   channel   dir  handshake           word
//   pair_i    in   valid/ready         two block colors and last_block
//   result_o  out  valid/ready         average_diff, stopped_early
//   apb       in   psel/penable/pready diff_limit (0x0), min_blocks_before_stop (0x4)
//
// A counted pair goes through accept, three channel steps that add to the total,
// a threshold step and a compare step, all on the one shared add/subtract unit. A
// pair after a stop or past MaxBlocks is accepted but not counted. The last pair adds a
// decide step, then, unless stopped, SumW (18) restoring division steps on the same
// unit and one fixup step, then the output cycle. Reset is asynchronous and clears the
// running state. The input is not ready while a result waits on result_o.
`timescale 1ns / 1ps

module rgb_signature_mean_abs_diff (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rsmad_pair_if.sink                     pair_i,
  rsmad_result_if.source                 result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsmad_pkg::CfgAddrW-1:0] paddr,
  input  logic [rsmad_pkg::CfgDataW-1:0] pwdata,
  output logic [rsmad_pkg::CfgDataW-1:0] prdata,
  output logic                           pready
);
  import rsmad_pkg::*;

  state_e state_q, state_d;

  logic [LimitW-1:0]  limit_q;
  logic [MinW-1:0]    min_q;

  logic [ColorW-1:0]  a_q [3];
  logic [ColorW-1:0]  b_q [3];
  logic               last_q;
  logic [1:0]         ch_q;

  logic [SumW-1:0]    total_q;
  logic [SumW-1:0]    ltp_q;
  logic [CntW-1:0]    cnt_q;
  logic               stop_q;

  logic [CntW-1:0]    rem_q;
  logic [CntW-1:0]    divisor_q;
  logic [SumW-1:0]    quo_q;
  logic [DivCntW-1:0] step_q;

  logic [AvgW-1:0]    avg_q;
  logic               stop_out_q;

  logic               accept;
  logic               skip;
  logic               cfg_wr;
  cfg_reg_e           cfg_idx;

  logic [SumW-1:0]    alu_a, alu_b;
  logic               alu_sub;
  logic [SumW:0]      alu_sum;
  logic               alu_carry;

  logic [ColorW-1:0]  ch_a, ch_b, ch_abs;
  logic [CntW:0]      rem_shift;
  logic [AvgW:0]      limit_plus;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      min_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DIFF_LIMIT: limit_q <= pwdata[LimitW-1:0];
        REG_MIN_BLOCKS: min_q   <= pwdata[MinW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DIFF_LIMIT: prdata = CfgDataW'(limit_q);
      REG_MIN_BLOCKS: prdata = CfgDataW'(min_q);
      default:        prdata = '0;
    endcase
  end

  // Shared add/subtract unit
  assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {SumW{alu_sub}}} + (SumW + 1)'(alu_sub);
  assign alu_carry = alu_sum[SumW];

  assign ch_a      = a_q[ch_q];
  assign ch_b      = b_q[ch_q];
  assign ch_abs    = (ch_a > ch_b) ? (ch_a - ch_b) : (ch_b - ch_a);
  assign rem_shift = {rem_q, quo_q[SumW-1]};
  assign limit_plus = {1'b0, limit_q} + (AvgW + 1)'(1);

  assign accept = pair_i.valid & pair_i.ready;
  assign skip   = stop_q | (cnt_q == CntW'(MaxBlocks));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!skip) state_d = S_DIFF;
          else if (pair_i.last_block) state_d = S_DECIDE;
        end
      end
      S_DIFF:   if (ch_q == 2'd2) state_d = S_LIMIT;
      S_LIMIT:  state_d = S_CHECK;
      S_CHECK:  state_d = last_q ? S_DECIDE : S_IDLE;
      S_DECIDE: state_d = stop_q ? S_OUT : S_DIV;
      S_DIV:    if (step_q == '0) state_d = S_FIX;
      S_FIX:    state_d = S_OUT;
      S_OUT:    if (result_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs and unit control
  always_comb begin
    pair_i.ready   = 1'b0;
    result_o.valid = 1'b0;
    alu_a          = total_q;
    alu_b          = SumW'(ch_abs);
    alu_sub        = 1'b0;
    unique case (state_q)
      S_IDLE:  pair_i.ready = 1'b1;
      S_DIFF: begin
        alu_a = total_q;
        alu_b = SumW'(ch_abs);
      end
      S_LIMIT: begin
        alu_a = ltp_q;
        alu_b = SumW'(limit_q);
      end
      S_CHECK: begin
        alu_a   = ltp_q;
        alu_b   = total_q;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = SumW'(rem_shift);
        alu_b   = SumW'(divisor_q);
        alu_sub = 1'b1;
      end
      S_OUT:   result_o.valid = 1'b1;
      default: ;
    endcase
  end

  assign result_o.average_diff  = avg_q;
  assign result_o.stopped_early = stop_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Input word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q[0] <= pair_i.first_red;
      a_q[1] <= pair_i.first_green;
      a_q[2] <= pair_i.first_blue;
      b_q[0] <= pair_i.second_red;
      b_q[1] <= pair_i.second_green;
      b_q[2] <= pair_i.second_blue;
      last_q <= pair_i.last_block;
    end
  end

  // Running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q    <= '0;
      total_q <= '0;
      ltp_q   <= '0;
      cnt_q   <= '0;
      stop_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: ch_q <= '0;
        S_DIFF: begin
          total_q <= alu_sum[SumW-1:0];
          ch_q    <= ch_q + 2'd1;
        end
        S_LIMIT: begin
          ltp_q <= alu_sum[SumW-1:0];
          cnt_q <= cnt_q + CntW'(1);
        end
        S_CHECK: begin
          // no carry out of ltp - total means total exceeds the threshold
          if (!alu_carry && (CmpW'(cnt_q) >= CmpW'(min_q))) stop_q <= 1'b1;
        end
        S_OUT: begin
          if (result_o.ready) begin
            total_q <= '0;
            ltp_q   <= '0;
            cnt_q   <= '0;
            stop_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Division and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      avg_q      <= '0;
      stop_out_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_DECIDE: begin
          step_q     <= DivCntW'(SumW - 1);
          stop_out_q <= stop_q;
          if (limit_plus[AvgW]) avg_q <= '1;
          else                  avg_q <= limit_plus[AvgW-1:0];
        end
        S_DIV: step_q <= step_q - DivCntW'(1);
        S_FIX: begin
          // saturate wide quotients, and lift a zero quotient of a nonzero total
          if (|quo_q[SumW-1:AvgW])                   avg_q <= '1;
          else if (quo_q == '0 && total_q != '0)     avg_q <= AvgW'(1);
          else                                       avg_q <= quo_q[AvgW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_DECIDE: begin
        rem_q     <= '0;
        quo_q     <= total_q;
        divisor_q <= (cnt_q == '0) ? CntW'(1) : cnt_q;
      end
      S_DIV: begin
        if (alu_carry) rem_q <= alu_sum[CntW-1:0];
        else           rem_q <= rem_shift[CntW-1:0];
        quo_q <= {quo_q[SumW-2:0], alu_carry};
      end
      default: ;
    endcase
  end

endmodule
